/* hdl/sfs_pkg.sv */
// Shared types and constants for the sprite frame sequencer.
package sfs_pkg;

  localparam int unsigned NUM_FRAMES = 64;
  localparam int unsigned TICK_W     = 40;
  localparam int unsigned PACE_W     = 16;
  localparam int unsigned FRAME_W    = 6;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned RNG_W      = 7;
  localparam int unsigned EVT_W      = 64;
  localparam int unsigned MOD_W      = 22;
  localparam int unsigned DVS_W      = PACE_W + FRAME_W - 1;
  localparam int unsigned CNT_W      = $clog2(TICK_W);
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST      = 3'd0,
    CFG_LAST       = 3'd1,
    CFG_PACE       = 3'd2,
    CFG_CONTINUOUS = 3'd3,
    CFG_FINAL_EN   = 3'd4,
    CFG_EVENTS     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [FRAME_W-1:0] first;
    logic [FRAME_W-1:0] last;
    logic [PACE_W-1:0]  pace;
    logic               continuous;
    logic               final_en;
    logic [EVT_W-1:0]   events;
    logic               clr_final;
    logic [EVT_W-1:0]   clr_fired;
  } cfg_t;

endpackage

/* hdl/sfs_cfg_regs.sv */
// Configuration register file with flag-clear strobes.
module sfs_cfg_regs import sfs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [EVT_W-1:0]     cfg_data_i,
  output cfg_t                 cfg_o
);

  logic [FRAME_W-1:0] first_q, last_q;
  logic [PACE_W-1:0]  pace_q;
  logic               cont_q, fin_en_q;
  logic [EVT_W-1:0]   events_q;
  logic               wr;

  assign cfg_ready_o = 1'b1;
  assign wr = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      last_q   <= FRAME_W'(NUM_FRAMES - 1);
      pace_q   <= PACE_W'(1);
      cont_q   <= 1'b1;
      fin_en_q <= 1'b0;
      events_q <= '0;
    end else if (wr) begin
      case (cfg_index_i)
        CFG_FIRST:      first_q  <= cfg_data_i[FRAME_W-1:0];
        CFG_LAST:       last_q   <= cfg_data_i[FRAME_W-1:0];
        CFG_PACE:       pace_q   <= cfg_data_i[PACE_W-1:0];
        CFG_CONTINUOUS: cont_q   <= cfg_data_i[0];
        CFG_FINAL_EN:   fin_en_q <= cfg_data_i[0];
        CFG_EVENTS:     events_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o            = '0;
    cfg_o.first      = first_q;
    cfg_o.last       = last_q;
    cfg_o.pace       = pace_q;
    cfg_o.continuous = cont_q;
    cfg_o.final_en   = fin_en_q;
    cfg_o.events     = events_q;
    cfg_o.clr_final  = wr && (cfg_index_i == CFG_FINAL_EN);
    cfg_o.clr_fired  = (wr && (cfg_index_i == CFG_EVENTS)) ? cfg_data_i : '0;
  end

endmodule

/* hdl/sfs_div_unit.sv */
// Iterative modulo then divide on one shared subtractor.
module sfs_div_unit import sfs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [TICK_W-1:0]  ticks_i,
  input  logic [PACE_W-1:0]  pace_i,
  input  logic [RNG_W-1:0]   range_i,
  output logic               done_o,
  output logic [FRAME_W-1:0] quot_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  logic [1:0]              st_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    done_q;
  logic [TICK_W-1:0]       ticks_q;
  logic [PACE_W-1:0]       pace_q;
  logic [RNG_W-1:0]        rng_q;
  logic [MOD_W-1:0]        mod_q, rem_q, next_rem;
  logic [DVS_W-1:0]        dvs_q;
  logic [FRAME_W-1:0]      quot_q;
  logic [PACE_W+RNG_W-1:0] prod;
  logic [MOD_W:0]          sub_a, sub_b;
  logic [MOD_W+1:0]        diff;
  logic                    borrow;

  assign prod = pace_q * rng_q;

  // shared compare/subtract
  always_comb begin
    if (st_q == S_MOD) begin
      sub_a = {rem_q, ticks_q[TICK_W-1]};
      sub_b = {1'b0, mod_q};
    end else begin
      sub_a = {1'b0, rem_q};
      sub_b = (MOD_W+1)'(dvs_q);
    end
    diff     = {1'b0, sub_a} - {1'b0, sub_b};
    borrow   = diff[MOD_W+1];
    next_rem = borrow ? sub_a[MOD_W-1:0] : diff[MOD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (st_q == S_DIV) && (cnt_q == '0);
      case (st_q)
        S_IDLE: if (start_i) st_q <= S_MUL;
        S_MUL: begin
          cnt_q <= CNT_W'(TICK_W - 1);
          st_q  <= S_MOD;
        end
        S_MOD: begin
          if (cnt_q == '0) begin
            cnt_q <= CNT_W'(FRAME_W - 1);
            st_q  <= S_DIV;
          end else begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end
        S_DIV: begin
          if (cnt_q == '0) begin
            st_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        if (start_i) begin
          ticks_q <= ticks_i;
          pace_q  <= pace_i;
          rng_q   <= range_i;
        end
      end
      S_MUL: begin
        mod_q <= prod[MOD_W-1:0];
        rem_q <= '0;
        dvs_q <= {pace_q, (FRAME_W-1)'(0)};
      end
      S_MOD: begin
        rem_q   <= next_rem;
        ticks_q <= ticks_q << 1;
      end
      S_DIV: begin
        rem_q  <= next_rem;
        quot_q <= {quot_q[FRAME_W-2:0], ~borrow};
        dvs_q  <= dvs_q >> 1;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* hdl/sprite_frame_sequencer.sv */
// Sprite frame sequencer top level: item control, event flags, output register.
//
//  channel  | direction | words
//  s_axis   | in        | tuser: opcode; tdata: elapsed_ticks, frame_count
//  m_axis   | out       | tdata: updated, frame_index, flags
//  cfg      | in        | register index and write data
//
// A tick item runs one multiply, one modulo step per tick bit and six divide
// steps; the modulo and divide steps share one subtractor.
// Restore, suspended and error items skip the divider and go straight to the output stage.
// One item at a time; s_axis_tready is low until the result is in the output register.
// The output register holds a word while m_axis_tready is low.
// Reset clears flags, state and configuration to their defaults.
module sprite_frame_sequencer import sfs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [39:0] elapsed_ticks, [46:40] frame_count
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] opcode
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] updated, [6:1] frame_index, [7] event_hit, [8] final_event,
  // [9] now_suspended, [10] range_error
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [EVT_W-1:0]      cfg_data_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_RESTORE = 2'd1;
  localparam logic [1:0] KIND_HOLD    = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  cfg_t cfg;

  logic [1:0]            state_q;
  logic [1:0]            kind_q, kind_c;
  logic [FRAME_W-1:0]    last_q, last_c;
  logic                  susp_q, susp_d;
  logic                  fin_rep_q, fin_rep_d;
  logic [EVT_W-1:0]      fired_q, fired_d;
  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  logic                  s_fire, out_free, emit;
  logic [COUNT_W-1:0]    in_count, cnt_clamp;
  logic                  err_c;
  logic [RNG_W-1:0]      rng_c;
  logic [PACE_W-1:0]     pace_c;
  logic                  div_done;
  logic [FRAME_W-1:0]    div_quot, frame;
  logic                  upd, hit, fin, err, at_last;
  logic [OUT_DATA_W-1:0] res;

  sfs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~m_valid_q | m_axis_tready;
  assign emit          = (state_q == ST_EMIT) & out_free;

  // range set-up at accept
  always_comb begin
    in_count  = s_axis_tdata[TICK_W+COUNT_W-1:TICK_W];
    cnt_clamp = (in_count > COUNT_W'(NUM_FRAMES)) ? COUNT_W'(NUM_FRAMES) : in_count;
    if (cnt_clamp <= {1'b0, cfg.last}) begin
      last_c = FRAME_W'(cnt_clamp - COUNT_W'(1));
    end else begin
      last_c = cfg.last;
    end
    err_c  = (cnt_clamp == '0) || (cfg.first > last_c);
    rng_c  = {1'b0, last_c} - {1'b0, cfg.first} + RNG_W'(1);
    pace_c = (cfg.pace == '0) ? PACE_W'(1) : cfg.pace;
    if (s_axis_tuser) begin
      kind_c = KIND_RESTORE;
    end else if (susp_q) begin
      kind_c = KIND_HOLD;
    end else if (err_c) begin
      kind_c = KIND_ERROR;
    end else begin
      kind_c = KIND_TICK;
    end
  end

  sfs_div_unit u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s_fire && (kind_c == KIND_TICK)),
    .ticks_i (s_axis_tdata[TICK_W-1:0]),
    .pace_i  (pace_c),
    .range_i (rng_c),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // result and flag update
  always_comb begin
    frame     = cfg.first + div_quot;
    at_last   = (frame >= last_q);
    upd       = 1'b0;
    hit       = 1'b0;
    fin       = 1'b0;
    err       = 1'b0;
    susp_d    = susp_q;
    fin_rep_d = fin_rep_q;
    fired_d   = fired_q & ~cfg.clr_fired;
    if (cfg.clr_final) fin_rep_d = 1'b0;
    case (kind_q)
      KIND_RESTORE: begin
        susp_d    = 1'b0;
        fin_rep_d = 1'b0;
        fired_d   = '0;
      end
      KIND_HOLD:  ;
      KIND_ERROR: err = 1'b1;
      KIND_TICK: begin
        upd     = 1'b1;
        hit     = cfg.events[frame] & ~fired_q[frame];
        fired_d = fired_q | (EVT_W'(hit) << frame);
        if (at_last) begin
          fired_d = '0;
          if (!cfg.continuous) begin
            fin       = cfg.final_en & ~fin_rep_q;
            fin_rep_d = fin_rep_q | fin;
            susp_d    = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res = OUT_DATA_W'({err, susp_d, fin, hit, upd ? frame : FRAME_W'(0), upd});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      kind_q    <= KIND_TICK;
      susp_q    <= 1'b0;
      fin_rep_q <= 1'b0;
      fired_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          fired_q <= fired_q & ~cfg.clr_fired;
          if (cfg.clr_final) fin_rep_q <= 1'b0;
          if (s_fire) begin
            kind_q  <= kind_c;
            state_q <= (kind_c == KIND_TICK) ? ST_CALC : ST_EMIT;
          end
        end
        ST_CALC: if (div_done) state_q <= ST_EMIT;
        ST_EMIT: begin
          if (emit) begin
            susp_q    <= susp_d;
            fin_rep_q <= fin_rep_d;
            fired_q   <= fired_d;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) last_q <= last_c;
    if (emit) m_data_q <= res;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

/* verif/tb_sprite_frame_sequencer.sv */
// Testbench for sprite_frame_sequencer: directed and random ticks checked against a predictor.
`timescale 1ns / 100ps

module tb_sprite_frame_sequencer;
  import sfs_pkg::*;

  localparam bit OP_TICK    = 1'b0;
  localparam bit OP_RESTORE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam int unsigned ITEM_TARGET    = 600;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES   = 80;
  localparam int unsigned CYCLE_LIMIT    = 1000000;

  typedef struct packed {
    logic [OUT_DATA_W-12:0] pad;
    logic                   range_error;
    logic                   now_suspended;
    logic                   final_event;
    logic                   event_hit;
    logic [FRAME_W-1:0]     frame_index;
    logic                   updated;
  } frame_word_t;

  class frame_scoreboard;
    logic [FRAME_W-1:0] first;
    logic [FRAME_W-1:0] last;
    logic [PACE_W-1:0]  pace;
    logic               continuous;
    logic               final_en;
    logic [EVT_W-1:0]   events;
    logic [EVT_W-1:0]   fired;
    logic               suspended;
    logic               final_seen;
    frame_word_t        expected_frames[$];
    int unsigned        errors;

    function new();
      first      = '0;
      last       = '1;
      pace       = PACE_W'(1);
      continuous = 1'b1;
      final_en   = 1'b0;
      events     = '0;
      fired      = '0;
      suspended  = 1'b0;
      final_seen = 1'b0;
      errors     = 0;
    endfunction

    function int unsigned pending();
      return expected_frames.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [EVT_W-1:0] data);
      case (idx)
        CFG_FIRST:      first = data[FRAME_W-1:0];
        CFG_LAST:       last = data[FRAME_W-1:0];
        CFG_PACE:       pace = data[PACE_W-1:0];
        CFG_CONTINUOUS: continuous = data[0];
        CFG_FINAL_EN: begin
          final_en   = data[0];
          final_seen = 1'b0;
        end
        CFG_EVENTS: begin
          events = data;
          fired  = fired & ~data;
        end
        default: ;
      endcase
    endfunction

    function void note_word(bit op, logic [TICK_W-1:0] ticks, logic [COUNT_W-1:0] count);
      frame_word_t       res;
      longint unsigned   cnt;
      longint unsigned   lo;
      longint unsigned   hi;
      longint unsigned   step;
      longint unsigned   span;
      longint unsigned   frame;
      res = '0;
      if (op == OP_RESTORE) begin
        fired      = '0;
        final_seen = 1'b0;
        suspended  = 1'b0;
      end else if (suspended) begin
        res.now_suspended = 1'b1;
      end else begin
        cnt = (count > NUM_FRAMES) ? NUM_FRAMES : count;
        lo  = first;
        hi  = last;
        if (cnt != 0 && cnt <= hi) hi = cnt - 1;
        if (cnt == 0 || lo > hi) begin
          res.range_error = 1'b1;
        end else begin
          step  = (pace == 0) ? 1 : pace;
          span  = step * (hi - lo + 1);
          frame = lo + (longint'(ticks) % span) / step;
          if (events[frame] && !fired[frame]) begin
            res.event_hit = 1'b1;
            fired[frame]  = 1'b1;
          end
          if (frame >= hi) begin
            fired = '0;
            if (!continuous) begin
              if (final_en && !final_seen) begin
                res.final_event = 1'b1;
                final_seen      = 1'b1;
              end
              suspended = 1'b1;
            end
          end
          res.updated       = 1'b1;
          res.frame_index   = frame[FRAME_W-1:0];
          res.now_suspended = suspended;
        end
      end
      expected_frames.push_back(res);
    endfunction

    function void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(logic [OUT_DATA_W-1:0] data);
      frame_word_t want;
      frame_word_t got;
      got = frame_word_t'(data);
      if (expected_frames.size() == 0) begin
        $error("result word with nothing outstanding: %h", data);
        errors++;
        return;
      end
      want = expected_frames.pop_front();
      check_field("updated", want.updated, got.updated);
      check_field("frame_index", want.frame_index, got.frame_index);
      check_field("event_hit", want.event_hit, got.event_hit);
      check_field("final_event", want.final_event, got.final_event);
      check_field("now_suspended", want.now_suspended, got.now_suspended);
      check_field("range_error", want.range_error, got.range_error);
      check_field("padding", want.pad, got.pad);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [EVT_W-1:0]      cfg_data_i = '0;

  frame_scoreboard   sb;
  bit                idle_on = 1'b1;
  bit                rx_hold_req = 1'b0;
  int unsigned       items_sent = 0;
  int unsigned       cycle_count = 0;
  logic [TICK_W-1:0] run_ticks = '0;

  sprite_frame_sequencer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver side: random stalls plus the occasional long hold-off
  initial begin : rx_side
    int unsigned hold;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        hold        = RX_HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  task automatic send_word(bit op, logic [TICK_W-1:0] ticks, logic [COUNT_W-1:0] count);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_DATA_W-TICK_W-COUNT_W){1'b0}}, count, ticks};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(op, ticks, count);
    items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // leaves cfg_valid_i high; the caller lowers it after the last write of a batch
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [EVT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  function automatic logic [EVT_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_setting();
    logic [EVT_W-1:0] v;
    int unsigned      r;
    int unsigned      lo;
    int unsigned      hi;
    if ($urandom_range(0, 1)) begin
      r  = $urandom_range(0, 99);
      lo = (r < 15) ? 0 : (r < 25) ? 63 : $urandom_range(0, 20);
      v  = rand64();
      v[FRAME_W-1:0] = FRAME_W'(lo);
      cfg_write(CFG_FIRST, v);
    end
    if ($urandom_range(0, 1)) begin
      r  = $urandom_range(0, 99);
      hi = sb.first + $urandom_range(0, 20);
      if (hi > 63) hi = 63;
      if (r < 15) hi = 63;
      else if (r < 25) hi = 0;
      v = rand64();
      v[FRAME_W-1:0] = FRAME_W'(hi);
      cfg_write(CFG_LAST, v);
    end
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 99);
      v = rand64();
      if (r < 30) v[PACE_W-1:0] = PACE_W'(1);
      else if (r < 40) v[PACE_W-1:0] = '0;
      else if (r < 50) v[PACE_W-1:0] = '1;
      else v[PACE_W-1:0] = PACE_W'($urandom_range(1, 64));
      cfg_write(CFG_PACE, v);
    end
    if ($urandom_range(0, 1)) cfg_write(CFG_CONTINUOUS, rand64());
    if ($urandom_range(0, 1)) cfg_write(CFG_FINAL_EN, rand64());
    if ($urandom_range(0, 1)) cfg_write(CFG_EVENTS, rand64());
    if ($urandom_range(0, 9) == 0) cfg_write(CFG_SPARE_LO, rand64());
    if ($urandom_range(0, 9) == 0) cfg_write(CFG_SPARE_HI, rand64());
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_burst(int unsigned n);
    bit                 op;
    logic [TICK_W-1:0]  ticks;
    logic [COUNT_W-1:0] count;
    int unsigned        r;
    int unsigned        step;
    repeat (n) begin
      r  = $urandom_range(0, 99);
      op = (r < (sb.suspended ? 40 : 4)) ? OP_RESTORE : OP_TICK;
      r  = $urandom_range(0, 99);
      if (r < 50) count = COUNT_W'(64);
      else if (r < 80) count = COUNT_W'($urandom_range(1, 64));
      else if (r < 90) count = '0;
      else count = COUNT_W'($urandom_range(65, 127));
      r    = $urandom_range(0, 99);
      step = (sb.pace == 0) ? 1 : sb.pace;
      if (r < 70) begin
        run_ticks = run_ticks + $urandom_range(0, step);
        ticks     = run_ticks;
      end else if (r < 85) begin
        ticks = TICK_W'(rand64());
      end else if (r < 95) begin
        ticks = TICK_W'($urandom_range(0, 200));
      end else begin
        ticks = '1;
      end
      send_word(op, ticks, count);
    end
  endtask

  initial begin : stimulus
    int unsigned phase;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: whole 64-frame loop at pace 1
    send_word(OP_TICK, '0, 7'd64);
    send_word(OP_TICK, '1, 7'd64);
    send_word(OP_TICK, 40'd3, 7'd0);
    send_word(OP_TICK, 40'd100, 7'd127);
    send_word(OP_TICK, 40'd5, 7'd65);
    send_word(OP_TICK, 40'd7, 7'd1);
    send_word(OP_RESTORE, TICK_W'(rand64()), COUNT_W'($urandom_range(0, 127)));
    wait_drained();

    // one-shot over frames 5..10, zero pace, events on 5, 7, 10 and 63
    cfg_write(CFG_FIRST, 64'd5);
    cfg_write(CFG_LAST, 64'd10);
    cfg_write(CFG_PACE, 64'd0);
    cfg_write(CFG_CONTINUOUS, 64'd0);
    cfg_write(CFG_FINAL_EN, 64'd1);
    cfg_write(CFG_EVENTS, (64'd1 << 5) | (64'd1 << 7) | (64'd1 << 10) | (64'd1 << 63));
    cfg_write(CFG_SPARE_LO, rand64());
    cfg_write(CFG_SPARE_HI, rand64());
    cfg_valid_i <= 1'b0;
    send_word(OP_TICK, 40'd0, 7'd64);
    send_word(OP_TICK, 40'd0, 7'd64);
    send_word(OP_TICK, 40'd2, 7'd64);
    send_word(OP_TICK, 40'd5, 7'd64);
    send_word(OP_TICK, 40'd3, 7'd64);
    send_word(OP_RESTORE, '0, 7'd0);
    send_word(OP_TICK, 40'd2, 7'd8);
    send_word(OP_RESTORE, '1, 7'd127);
    send_word(OP_TICK, 40'd0, 7'd4);
    wait_drained();

    // single frame at the top, slowest pace, every frame marked
    cfg_write(CFG_FIRST, 64'd63);
    cfg_write(CFG_LAST, 64'd63);
    cfg_write(CFG_PACE, 64'hFFFF);
    cfg_write(CFG_CONTINUOUS, 64'd1);
    cfg_write(CFG_EVENTS, '1);
    cfg_valid_i <= 1'b0;
    send_word(OP_TICK, TICK_W'(rand64()), 7'd64);
    send_word(OP_TICK, '1, 7'd127);
    send_word(OP_TICK, 40'd0, 7'd63);
    wait_drained();

    cfg_write(CFG_FIRST, 64'd0);
    cfg_write(CFG_EVENTS, 64'd0);
    cfg_write(CFG_FINAL_EN, 64'd0);
    cfg_valid_i <= 1'b0;
    send_word(OP_TICK, '1, 7'd64);
    send_word(OP_TICK, 40'(65535 * 64 - 1), 7'd64);
    send_word(OP_TICK, 40'd65535, 7'd64);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_drained();
      random_setting();
      idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 2 || phase == 11) rx_hold_req = 1'b1;
      random_burst($urandom_range(10, 50));
      phase++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sprite_frame_sequencer.f */
hdl/sfs_pkg.sv
hdl/sfs_cfg_regs.sv
hdl/sfs_div_unit.sv
hdl/sprite_frame_sequencer.sv
verif/tb_sprite_frame_sequencer.sv
